### design/mci_pkg.sv
`default_nettype none

package mci_pkg;

   // table geometry
   localparam int unsigned TableDepth = 11;
   localparam int unsigned LastIndex = TableDepth - 1;
   localparam int unsigned IndexWidth = $clog2(TableDepth);
   localparam int unsigned EntryWidth = 16;

   // default fill
   localparam int unsigned FirstDefault = 1700;
   localparam int unsigned LastDefault = 3000;
   localparam int unsigned DefaultStep = (LastDefault - FirstDefault) / TableDepth;

   // percent scale
   localparam int unsigned PctStep = 10;
   localparam int unsigned FullPct = 100;
   localparam int unsigned PctLimit = (LastIndex + 1) * PctStep;

   // field widths
   localparam int unsigned PercentWidth = 8;
   localparam int unsigned ReadingWidth = 14;
   localparam int unsigned MoistWidth = 7;

   // arithmetic unit width: scaled remainder and shifted divisor
   localparam int unsigned RemWidth = 18;
   localparam int unsigned AluWidth = 19;
   localparam int unsigned QuotWidth = 4;

   // request opcodes
   localparam logic OpSet = 1'b0;
   localparam logic OpConvert = 1'b1;

   // table write port
   typedef struct packed {
      logic                  we;
      logic [IndexWidth-1:0] addr;
      logic [EntryWidth-1:0] data;
   } mci_wr_type;

   // reset value of one table entry
   function automatic logic [EntryWidth-1:0] default_entry(input int unsigned idx);
      logic [EntryWidth-1:0] val;
      if (idx == LastIndex) val = EntryWidth'(LastDefault);
      else val = EntryWidth'(FirstDefault + DefaultStep * idx);
      return val;
   endfunction

   // percent / 10 by reciprocal, exact for percent below PctLimit
   function automatic logic [IndexWidth-1:0] pct_to_index(input logic [PercentWidth-1:0] pct);
      logic [15:0] prod;
      prod = 16'(pct) * 16'd205;
      return prod[11 +: IndexWidth];
   endfunction

endpackage

`default_nettype wire

### design/mci_if.sv
`default_nettype none

// request channel
interface mci_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    op;
   logic [mci_pkg::PercentWidth-1:0]        point_percent;
   logic [mci_pkg::EntryWidth-1:0]          point_value;
   logic [mci_pkg::ReadingWidth-1:0]        cap_reading;
   logic                                    reading_valid;

   modport source (output valid, op, point_percent, point_value, cap_reading,
                   reading_valid, input ready);
   modport sink (input valid, op, point_percent, point_value, cap_reading,
                 reading_valid, output ready);
endinterface

// response channel
interface mci_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [mci_pkg::MoistWidth-1:0]          moisture_percent;
   logic                                    accepted;

   modport source (output valid, moisture_percent, accepted, input ready);
   modport sink (input valid, moisture_percent, accepted, output ready);
endinterface

`default_nettype wire

### design/mci_alu.sv
`default_nettype none

// shared subtract / compare unit
module mci_alu (
   input  wire logic [mci_pkg::AluWidth-1:0] alu_a,
   input  wire logic [mci_pkg::AluWidth-1:0] alu_b,
   output logic      [mci_pkg::AluWidth-1:0] alu_diff,
   output logic                              alu_borrow
);

   logic [mci_pkg::AluWidth:0] full_diff;

   // borrow set when a < b
   always_comb begin
      full_diff = {1'b0, alu_a} - {1'b0, alu_b};
      alu_diff = full_diff[mci_pkg::AluWidth-1:0];
      alu_borrow = full_diff[mci_pkg::AluWidth];
   end

endmodule

`default_nettype wire

### design/mci_table.sv
`default_nettype none

// calibration table: register file, one write and one read port
module mci_table (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mci_pkg::mci_wr_type                wr,
   input  wire logic [mci_pkg::IndexWidth-1:0]     rd_addr,
   output logic      [mci_pkg::EntryWidth-1:0]     rd_data
);

   logic [mci_pkg::EntryWidth-1:0] entry_ff [mci_pkg::TableDepth];

   // entries reset to the default fill
   always_ff @(posedge clock) begin
      for (int i = 0; i < mci_pkg::TableDepth; i++) begin
         if (reset) begin
            entry_ff[i] <= mci_pkg::default_entry(i);
         end else if (wr.we && (wr.addr == mci_pkg::IndexWidth'(i))) begin
            entry_ff[i] <= wr.data;
         end
      end
   end

   // read mux; sequencer keeps the address in range
   always_comb begin
      rd_data = entry_ff[0];
      for (int i = 1; i < mci_pkg::TableDepth; i++) begin
         if (rd_addr == mci_pkg::IndexWidth'(i)) rd_data = entry_ff[i];
      end
   end

endmodule

`default_nettype wire

### design/moisture_calibration_interpolator.sv
`default_nettype none

// Channel   Port      Dir  Beat
// request   req_chan  in   op, point_percent, point_value, cap_reading, reading_valid
// response  rsp_chan  out  moisture_percent, accepted
//
// Set and invalid convert beats go from idle straight to the finish state; a convert
// beat searches the table and finishes there when the reading falls below the first
// entry or at or above them all, else runs two subtracts, then four restoring divide steps.
// The search reads one entry per cycle via the shared subtractor.
// req_chan.ready is high only while idle; a response held by rsp_chan.ready keeps
// the next result in the finish state. Synchronous reset restores the default fill.

module moisture_calibration_interpolator (
   input  wire logic  clock,
   input  wire logic  reset,
   mci_req_if.sink    req_chan,
   mci_rsp_if.source  rsp_chan
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StSearch = 3'd1;
   localparam logic [2:0] StSubLo  = 3'd2;
   localparam logic [2:0] StSubDen = 3'd3;
   localparam logic [2:0] StDiv    = 3'd4;
   localparam logic [2:0] StFinish = 3'd5;

   localparam int unsigned IW = mci_pkg::IndexWidth;
   localparam int unsigned EW = mci_pkg::EntryWidth;
   localparam int unsigned AW = mci_pkg::AluWidth;
   localparam int unsigned RW = mci_pkg::RemWidth;
   localparam int unsigned QW = mci_pkg::QuotWidth;
   localparam int unsigned MW = mci_pkg::MoistWidth;

   logic [2:0]                      state_ff, state_in;
   logic [mci_pkg::ReadingWidth-1:0] raw_ff, raw_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [EW-1:0]                   lo_ff, lo_in;
   logic [EW-1:0]                   hi_ff, hi_in;
   logic [RW-1:0]                   rem_ff, rem_in;
   logic [EW-1:0]                   den_ff, den_in;
   logic [1:0]                      bit_ff, bit_in;
   logic [QW-1:0]                   quot_ff, quot_in;
   logic [MW-1:0]                   res_ff, res_in;
   logic                            acc_ff, acc_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]                   rsp_moist_ff, rsp_moist_in;
   logic                            rsp_acc_ff, rsp_acc_in;

   logic [AW-1:0]                   alu_a, alu_b, alu_diff;
   logic                            alu_borrow;
   logic [EW-1:0]                   tbl_data;
   mci_pkg::mci_wr_type             tbl_wr;
   logic                            req_fire;
   logic                            rsp_load;
   logic [QW-1:0]                   quot_next;
   logic [EW-1:0]                   lo_diff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == StFinish) && (!rsp_valid_ff || rsp_chan.ready);
   assign lo_diff = alu_diff[EW-1:0];

   mci_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_addr (idx_ff),
      .rd_data (tbl_data)
   );

   mci_alu u_alu (
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .alu_diff   (alu_diff),
      .alu_borrow (alu_borrow)
   );

   // operand select for the shared unit
   always_comb begin
      alu_a = AW'(raw_ff);
      alu_b = AW'(tbl_data);
      unique case (state_ff)
         StSubLo: begin
            alu_a = AW'(raw_ff);
            alu_b = AW'(lo_ff);
         end
         StSubDen: begin
            alu_a = AW'(hi_ff);
            alu_b = AW'(lo_ff);
         end
         StDiv: begin
            alu_a = AW'(rem_ff);
            alu_b = AW'(den_ff) << bit_ff;
         end
         default: begin
            alu_a = AW'(raw_ff);
            alu_b = AW'(tbl_data);
         end
      endcase
   end

   // table write on a set beat
   always_comb begin
      tbl_wr.we = req_fire && (req_chan.op == mci_pkg::OpSet) &&
                  (req_chan.point_percent < mci_pkg::PercentWidth'(mci_pkg::PctLimit));
      tbl_wr.addr = mci_pkg::pct_to_index(req_chan.point_percent);
      tbl_wr.data = req_chan.point_value;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      raw_in = raw_ff;
      idx_in = idx_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      bit_in = bit_ff;
      quot_in = quot_ff;
      res_in = res_ff;
      acc_in = acc_ff;
      quot_next = quot_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_fire) begin
               raw_in = req_chan.cap_reading;
               idx_in = '0;
               res_in = '0;
               if (req_chan.op == mci_pkg::OpSet) begin
                  acc_in = tbl_wr.we;
                  state_in = StFinish;
               end else if (req_chan.reading_valid) begin
                  acc_in = 1'b1;
                  state_in = StSearch;
               end else begin
                  acc_in = 1'b0;
                  state_in = StFinish;
               end
            end
         end
         StSearch: begin
            if (alu_borrow) begin
               // first entry above the reading
               hi_in = tbl_data;
               if (idx_ff == '0) begin
                  res_in = '0;
                  state_in = StFinish;
               end else begin
                  state_in = StSubLo;
               end
            end else begin
               lo_in = tbl_data;
               if (idx_ff == IW'(mci_pkg::LastIndex)) begin
                  res_in = MW'(mci_pkg::FullPct);
                  state_in = StFinish;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         StSubLo: begin
            // (raw - lo) * 10 as shift-add
            rem_in = (RW'(lo_diff) << 3) + (RW'(lo_diff) << 1);
            state_in = StSubDen;
         end
         StSubDen: begin
            den_in = lo_diff;
            bit_in = 2'd3;
            quot_in = '0;
            state_in = StDiv;
         end
         StDiv: begin
            // one restoring step per cycle
            if (!alu_borrow) begin
               rem_in = alu_diff[RW-1:0];
               quot_next[bit_ff] = 1'b1;
            end
            quot_in = quot_next;
            if (bit_ff == 2'd0) begin
               res_in = MW'(quot_next) +
                        MW'(idx_ff - 1'b1) * MW'(mci_pkg::PctStep);
               state_in = StFinish;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         StFinish: begin
            if (rsp_load) state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_moist_in = rsp_moist_ff;
      rsp_acc_in = rsp_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_moist_in = res_ff;
         rsp_acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff <= raw_in;
      idx_ff <= idx_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      bit_ff <= bit_in;
      quot_ff <= quot_in;
      res_ff <= res_in;
      acc_ff <= acc_in;
      rsp_moist_ff <= rsp_moist_in;
      rsp_acc_ff <= rsp_acc_in;
   end

   assign req_chan.ready = (state_ff == StIdle);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.moisture_percent = rsp_moist_ff;
   assign rsp_chan.accepted = rsp_acc_ff;

`ifndef SYNTHESIS
   // divisor is never zero once dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDiv) |-> (den_ff != '0))
      else $error("zero divisor in divide step");

   // search never runs past the last entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StSearch) |-> (idx_ff <= IW'(mci_pkg::LastIndex)))
      else $error("search index out of range");

   // a taken beat always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != StIdle))
      else $error("sequencer stayed idle after a beat");

   // refused results carry zero moisture, all results stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_acc_ff || (rsp_moist_ff == '0)) &&
                        (rsp_moist_ff <= MW'(mci_pkg::FullPct))))
      else $error("response moisture out of range");
`endif

endmodule

`default_nettype wire

### dv/moisture_calibration_checker.sv
`default_nettype none

// Watches both channels, predicts every response beat from the request beats
// and compares each response against the oldest prediction.
module moisture_calibration_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   mci_req_if          req_mon,
   mci_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned outstanding,
   output int unsigned checked_count
);

   typedef struct packed {
      logic [mci_pkg::MoistWidth-1:0] moisture;
      logic                           accepted;
   } moisture_result_type;

   // private copy of the calibration table
   logic [mci_pkg::EntryWidth-1:0] cap_table [mci_pkg::TableDepth];
   moisture_result_type            expected_moisture_q [$];

   // first entry strictly above the reading, then linear step inside the segment
   function automatic logic [mci_pkg::MoistWidth-1:0] interpolate_moisture(
      input logic [mci_pkg::ReadingWidth-1:0] reading
   );
      int unsigned raw;
      int unsigned lo;
      int unsigned hi;
      int unsigned pct;
      bit          found;
      raw = reading;
      pct = mci_pkg::FullPct;
      found = 1'b0;
      for (int i = 0; i < mci_pkg::TableDepth; i++) begin
         hi = cap_table[i];
         if (!found && raw < hi) begin
            found = 1'b1;
            if (i == 0) begin
               pct = 0;
            end else begin
               lo = cap_table[i-1];
               pct = ((raw - lo) * mci_pkg::PctStep) / (hi - lo)
                     + mci_pkg::PctStep * (i - 1);
            end
         end
      end
      return mci_pkg::MoistWidth'(pct);
   endfunction

   always @(posedge clock) begin
      moisture_result_type want;
      int unsigned         idx;
      if (reset) begin
         // default fill: fixed step from the first value, last entry pinned
         for (int i = 0; i < mci_pkg::TableDepth; i++) begin
            if (i == mci_pkg::LastIndex) begin
               cap_table[i] = mci_pkg::EntryWidth'(mci_pkg::LastDefault);
            end else begin
               cap_table[i] = mci_pkg::EntryWidth'(mci_pkg::FirstDefault
                  + i * ((mci_pkg::LastDefault - mci_pkg::FirstDefault)
                         / mci_pkg::TableDepth));
            end
         end
         expected_moisture_q.delete();
         outstanding <= 0;
      end else begin
         // response side: compare with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_moisture_q.size() == 0) begin
               $error("unexpected response beat: moisture_percent=%0d accepted=%0b",
                      rsp_mon.moisture_percent, rsp_mon.accepted);
               mismatch_count++;
            end else begin
               want = expected_moisture_q.pop_front();
               checked_count++;
               if (rsp_mon.moisture_percent !== want.moisture) begin
                  $error("moisture_percent mismatch: expected %0d, actual %0d",
                         want.moisture, rsp_mon.moisture_percent);
                  mismatch_count++;
               end
               if (rsp_mon.accepted !== want.accepted) begin
                  $error("accepted mismatch: expected %0b, actual %0b",
                         want.accepted, rsp_mon.accepted);
                  mismatch_count++;
               end
            end
         end
         // request side: predict and update the table copy
         if (req_mon.valid && req_mon.ready) begin
            want = '0;
            if (req_mon.op == mci_pkg::OpSet) begin
               idx = req_mon.point_percent / mci_pkg::PctStep;
               if (idx <= mci_pkg::LastIndex) begin
                  cap_table[idx] = req_mon.point_value;
                  want.accepted = 1'b1;
               end
            end else if (req_mon.reading_valid) begin
               want.moisture = interpolate_moisture(req_mon.cap_reading);
               want.accepted = 1'b1;
            end
            expected_moisture_q.push_back(want);
         end
         outstanding <= expected_moisture_q.size();
      end
   end

endmodule

`default_nettype wire

### dv/tb_moisture_calibration_interpolator.sv
`default_nettype none

module tb_moisture_calibration_interpolator;

   localparam int unsigned CycleLimit = 500000;
   localparam int unsigned HoldCycles = 400;
   localparam int unsigned PhaseBeats = 200;
   localparam int unsigned PhaseCount = 7;
   localparam int unsigned MaxReading = (1 << mci_pkg::ReadingWidth) - 1;
   localparam int unsigned TableDepth = mci_pkg::TableDepth;
   localparam int unsigned LastIndex = mci_pkg::LastIndex;
   localparam int unsigned PctStep = mci_pkg::PctStep;
   localparam int unsigned EW = mci_pkg::EntryWidth;
   localparam int unsigned PW = mci_pkg::PercentWidth;
   localparam int unsigned RdW = mci_pkg::ReadingWidth;
   localparam int unsigned DefaultStep =
      (mci_pkg::LastDefault - mci_pkg::FirstDefault) / mci_pkg::TableDepth;

   logic clock;
   logic reset;

   mci_req_if req_chan ();
   mci_rsp_if rsp_chan ();

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned checked;

   moisture_calibration_interpolator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   moisture_calibration_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatches),
      .outstanding    (outstanding),
      .checked_count  (checked)
   );

   // what the sender has written, only used to aim readings and nearby set values
   logic [EW-1:0] shadow [TableDepth];

   bit          sender_idle;
   bit          recv_idle;
   bit          hold_request;
   int unsigned beats_sent;
   int unsigned set_beats;
   int unsigned refused_sets;
   int unsigned convert_beats;
   int unsigned invalid_beats;
   int unsigned cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one request beat, with a random gap ahead of it while the sender idles
   task automatic send_beat(input logic op, input logic [PW-1:0] pct,
                            input logic [EW-1:0] val,
                            input logic [RdW-1:0] rd, input logic vld);
      int unsigned gap;
      gap = sender_idle ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.op            <= op;
      req_chan.point_percent <= pct;
      req_chan.point_value   <= val;
      req_chan.cap_reading   <= rd;
      req_chan.reading_valid <= vld;
      do @(posedge clock); while (!req_chan.ready);
      beats_sent++;
      if (op == mci_pkg::OpSet) begin
         set_beats++;
         if (pct / PctStep <= LastIndex) shadow[pct / PctStep] = val;
         else refused_sets++;
      end else begin
         convert_beats++;
         if (!vld) invalid_beats++;
      end
   endtask

   // unused fields carry random junk
   task automatic set_point(input int unsigned pct, input int unsigned val);
      send_beat(mci_pkg::OpSet, PW'(pct), EW'(val), RdW'($urandom), 1'($urandom));
   endtask

   task automatic convert_reading(input int unsigned rd, input bit vld);
      send_beat(mci_pkg::OpConvert, PW'($urandom), EW'($urandom), RdW'(rd), vld);
   endtask

   // drop valid and wait for every predicted response
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // fresh ascending table at random offset and random steps
   task automatic rebuild_table();
      int unsigned v;
      v = $urandom_range(0, 9000);
      for (int i = 0; i < TableDepth; i++) begin
         set_point(i * PctStep + $urandom_range(0, PctStep - 1), v);
         v += $urandom_range(1, 700);
      end
   endtask

   // reading inside a segment, on or next to an entry, or anywhere
   function automatic int unsigned aim_reading();
      int unsigned j;
      int unsigned span;
      int unsigned pick;
      int          target;
      pick = $urandom_range(0, 9);
      j = $urandom_range(0, LastIndex);
      if (pick < 5) begin
         span = (j < LastIndex && shadow[j+1] > shadow[j]) ? shadow[j+1] - shadow[j] : 64;
         target = int'(shadow[j]) + int'($urandom_range(0, span));
      end else if (pick < 8) begin
         target = int'(shadow[j]) + int'($urandom_range(0, 2)) - 1;
      end else begin
         target = $urandom_range(0, MaxReading);
      end
      if (target < 0) target = 0;
      if (target > int'(MaxReading)) target = MaxReading;
      return target;
   endfunction

   // one random beat: mostly valid conversions, some sets, some refusals
   task automatic random_beat();
      int unsigned r;
      int unsigned idx;
      int          v;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         convert_reading(aim_reading(), 1'b1);
      end else if (r < 70) begin
         convert_reading($urandom_range(0, MaxReading), 1'b0);
      end else if (r < 90) begin
         idx = $urandom_range(0, LastIndex);
         if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, 65535);
         end else begin
            v = int'(shadow[idx]) + int'($urandom_range(0, 400)) - 200;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
         end
         set_point(idx * PctStep + $urandom_range(0, PctStep - 1), v);
      end else begin
         set_point($urandom_range(mci_pkg::PctLimit, 255), $urandom_range(0, 65535));
      end
   endtask

   // response side: random stalls, plus one long hold on request
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            stall = recv_idle ? $urandom_range(0, 12) : 0;
            if (stall != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            do @(posedge clock); while (!rsp_chan.valid && !hold_request);
         end
      end
   end

   // stimulus
   initial begin
      int unsigned phase_end;
      req_chan.valid         = 1'b0;
      req_chan.op            = mci_pkg::OpSet;
      req_chan.point_percent = '0;
      req_chan.point_value   = '0;
      req_chan.cap_reading   = '0;
      req_chan.reading_valid = 1'b0;
      hold_request = 1'b0;
      sender_idle  = 1'b1;
      recv_idle    = 1'b1;
      for (int i = 0; i < TableDepth; i++) begin
         shadow[i] = (i == LastIndex) ? EW'(mci_pkg::LastDefault)
                     : EW'(mci_pkg::FirstDefault + i * DefaultStep);
      end
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: default table edges
      convert_reading(0, 1'b1);
      convert_reading(1699, 1'b1);
      convert_reading(1700, 1'b1);
      convert_reading(1759, 1'b1);
      convert_reading(2999, 1'b1);
      convert_reading(3000, 1'b1);
      convert_reading(MaxReading, 1'b1);
      // invalid readings
      convert_reading(MaxReading, 1'b0);
      convert_reading(0, 1'b0);
      // extremes of the set fields, refused indexes
      set_point(0, 0);
      convert_reading(0, 1'b1);
      set_point(109, 65535);
      convert_reading(MaxReading, 1'b1);
      set_point(mci_pkg::PctLimit, 12345);
      set_point(255, 65535);
      // table that dips in the middle
      set_point(55, 100);
      convert_reading(2000, 1'b1);
      convert_reading(2500, 1'b1);
      // first entry set to the largest reading, last entry dropped to zero, first entry above all
      set_point(9, MaxReading);
      convert_reading(MaxReading, 1'b1);
      set_point(100, 0);
      convert_reading(MaxReading, 1'b1);
      set_point(0, 65535);
      convert_reading(MaxReading, 1'b1);
      convert_reading(1, 1'b1);

      // random phases, idling on and off
      for (int phase = 0; phase < PhaseCount; phase++) begin
         sender_idle = (phase != 1);
         recv_idle   = (phase != 1 && phase != 4);
         phase_end = beats_sent + PhaseBeats;
         if (phase != 5) rebuild_table();
         while (beats_sent < phase_end) begin
            if (phase == 2 && beats_sent == phase_end - PhaseBeats / 2) begin
               // long response hold while the sender keeps pushing
               hold_request = 1'b1;
               sender_idle = 1'b0;
               repeat (30) random_beat();
               sender_idle = 1'b1;
            end else begin
               random_beat();
            end
         end
         if (phase % 2 == 1) wait_drained();
      end

      // drain and verdict
      wait_drained();
      repeat (40) @(posedge clock);
      $display("Run covered %0d set beats (%0d out of range) and %0d conversions (%0d invalid).",
               set_beats, refused_sets, convert_beats, invalid_beats);
      $display("%0d responses compared, with a %0d-cycle response hold and full drains.",
               checked, HoldCycles);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
